FILE: src/pth_pkg.sv
// ============================================================================
// Pan-tilt head tracker package
// Beat types, configuration layout and constants shared by the tracker files.
// ============================================================================
`default_nettype none

package pth_pkg;

    // Field widths of the input beat.
    localparam int X_W    = 13;
    localparam int Y_W    = 12;
    localparam int R_W    = 11;

    // Widths of the configuration registers.
    localparam int GAIN_W = 16;
    localparam int DZF_W  = 8;
    localparam int LIM_W  = 12;

    // Servo position width on the result beat.
    localparam int POS_W  = 12;

    // The dead zone factor carries this many fraction bits.
    localparam int DZ_FRAC_BITS = 8;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DZ_FACTOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_HIGH  = 3'd6;

    // Register values after reset.
    localparam logic [GAIN_W-1:0] RST_YAW_GAIN   = 16'd590;
    localparam logic [GAIN_W-1:0] RST_PITCH_GAIN = 16'd524;
    localparam logic [DZF_W-1:0]  RST_DZ_FACTOR  = 8'd192;
    localparam logic [LIM_W-1:0]  RST_YAW_LOW    = 12'd750;
    localparam logic [LIM_W-1:0]  RST_YAW_HIGH   = 12'd3346;
    localparam logic [LIM_W-1:0]  RST_PITCH_LOW  = 12'd1500;
    localparam logic [LIM_W-1:0]  RST_PITCH_HIGH = 12'd2650;

    // Home positions of the servos in whole counts.
    localparam logic [LIM_W-1:0] YAW_HOME   = 12'd2048;
    localparam logic [LIM_W-1:0] PITCH_HOME = 12'd2350;

    typedef struct packed {
        logic [X_W-1:0] ball_x;
        logic [Y_W-1:0] ball_y;
        logic [R_W-1:0] ball_radius;
    } in_beat_t;

    typedef struct packed {
        logic [POS_W-1:0] yaw_position;
        logic [POS_W-1:0] pitch_position;
        logic             positions_sent;
        logic             aim_done;
        logic             x_centered;
        logic             y_centered;
    } out_beat_t;

    typedef struct packed {
        logic [GAIN_W-1:0] yaw_gain;
        logic [GAIN_W-1:0] pitch_gain;
        logic [DZF_W-1:0]  dead_zone_factor;
        logic [LIM_W-1:0]  yaw_low_limit;
        logic [LIM_W-1:0]  yaw_high_limit;
        logic [LIM_W-1:0]  pitch_low_limit;
        logic [LIM_W-1:0]  pitch_high_limit;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/pan_tilt_head_tracker.sv
// ============================================================================
// Pan-tilt head tracker
// Proportional yaw and pitch servo tracking of a detected ball with a dead zone.
// ============================================================================
// Usage:
// Each input beat on s_* carries one detected ball (centre and radius in
// fixed point). Each accepted beat yields exactly one result beat on m_*
// with the updated servo positions and the centering and done flags.
// The configuration port takes gains, the dead zone factor and the servo
// limits; the user must write it only while no ball is being processed,
// since the block itself does not enforce this. A single shared multiplier
// runs the dead zone product and then, per axis, offset times radius and
// that times the gain, so the sequencer walks 10 steps per ball.
// s_ready is high only while the sequencer is idle. The finished result sits
// in an output register, so a new ball is accepted while it waits; if the
// receiver still stalls when the next ball finishes, the sequencer holds in
// its final step until the output register frees.
// Reset restores the default registers and the home positions of both
// servos and drops any pending result.
// ============================================================================
`default_nettype none

module pan_tilt_head_tracker #(
    parameter int IMAGE_WIDTH     = 320,
    parameter int IMAGE_HEIGHT    = 240,
    parameter int COORD_FRAC_BITS = 4,
    parameter int POS_FRAC_BITS   = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Ball detections
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire pth_pkg::in_beat_t              s_data,
    // Servo updates
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      pth_pkg::out_beat_t             m_data,
    // Configuration writes
    input  wire logic                           cfg_we,
    input  wire logic [pth_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pth_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pth_pkg::*;

    // Coordinates shifted up to the dead zone format.
    localparam int PXW    = X_W + DZ_FRAC_BITS;
    localparam int PYW    = Y_W + DZ_FRAC_BITS;
    localparam int DZW    = R_W + DZ_FRAC_BITS;
    localparam int HALF_X = IMAGE_WIDTH << (COORD_FRAC_BITS + 7);
    localparam int HALF_Y = IMAGE_HEIGHT << (COORD_FRAC_BITS + 7);
    localparam int HXW    = $clog2(HALF_X + 1);
    localparam int HYW    = $clog2(HALF_Y + 1);
    localparam int BW1    = (PXW > PYW) ? PXW : PYW;
    localparam int BW2    = (HXW > HYW) ? HXW : HYW;
    localparam int BW3    = (BW1 > BW2) ? BW1 : BW2;
    localparam int BW     = (BW3 > DZW) ? BW3 : DZW;
    // Signed offset width, multiplier operand width and product width.
    localparam int EW     = BW + 2;
    localparam int MA     = EW + R_W;
    localparam int PW     = MA + GAIN_W;
    localparam int SH     = 2 * COORD_FRAC_BITS + 24 - POS_FRAC_BITS;
    localparam int STW    = PW - SH;
    localparam int ACC    = 14 + POS_FRAC_BITS;
    localparam int SW     = ((STW > ACC) ? STW : ACC) + 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DZ   = 7'b0000010,
        ST_ERR  = 7'b0000100,
        ST_MUL1 = 7'b0001000,
        ST_MUL2 = 7'b0010000,
        ST_UPD  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    cfg_t cfg;

    state_t                  state_reg, state_next;
    logic                    axis_reg;
    in_beat_t                in_reg;
    logic [DZW-1:0]          dz_reg;
    logic signed [EW-1:0]    err_reg;
    logic signed [MA-1:0]    prod_reg;
    logic signed [STW-1:0]   step_reg;
    logic [1:0]              cen_reg;
    logic signed [ACC-1:0]   yaw_acc_reg, pitch_acc_reg;
    logic signed [ACC-1:0]   new_yaw_reg, new_pitch_reg;
    logic                    m_valid_reg;
    out_beat_t               out_reg;

    logic signed [MA-1:0]    mul_a;
    logic [GAIN_W-1:0]       mul_b;
    logic signed [PW:0]      mul_full;

    logic signed [EW-1:0]    p_val, half_val, dz_val, hi_bound, lo_bound, err_val;
    logic                    cen_val;

    logic signed [ACC-1:0]   acc_cur, sat_val, clamp_val;
    logic signed [SW-1:0]    sum_val;
    logic                    ovf;
    logic signed [ACC-1:0]   lim_hi, lim_lo, pitch_hi_full;

    logic                    fin_load, send, both_c;
    logic signed [ACC-1:0]   yaw_src, pitch_src;

    pth_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Integer part of a position, saturated to the servo range.
    function automatic logic [POS_W-1:0] int_part(input logic signed [ACC-1:0] v);
        logic [POS_W-1:0] r;
        if (v[ACC-1]) begin
            r = '0;
        end else if (v[ACC-2]) begin
            r = '1;
        end else begin
            r = v[POS_FRAC_BITS+POS_W-1:POS_FRAC_BITS];
        end
        return r;
    endfunction

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DZ: begin
                mul_a = MA'($signed({1'b0, in_reg.ball_radius}));
                mul_b = GAIN_W'(cfg.dead_zone_factor);
            end
            ST_MUL1: begin
                mul_a = MA'(err_reg);
                mul_b = GAIN_W'(in_reg.ball_radius);
            end
            ST_MUL2: begin
                mul_a = prod_reg;
                mul_b = axis_reg ? cfg.pitch_gain : cfg.yaw_gain;
            end
            default: begin
            end
        endcase
    end

    assign mul_full = $signed((PW+1)'(mul_a)) * $signed((PW+1)'({1'b0, mul_b}));

    // Offset from the image centre, widened by the dead zone outside it.
    always_comb begin
        p_val    = axis_reg ? $signed(EW'({in_reg.ball_y, {DZ_FRAC_BITS{1'b0}}}))
                            : $signed(EW'({in_reg.ball_x, {DZ_FRAC_BITS{1'b0}}}));
        half_val = axis_reg ? EW'(HALF_Y) : EW'(HALF_X);
        dz_val   = $signed(EW'(dz_reg));
        hi_bound = half_val + dz_val;
        lo_bound = half_val - dz_val;
        cen_val  = 1'b0;
        if (p_val >= hi_bound) begin
            err_val = p_val - half_val + dz_val;
        end else if (p_val <= lo_bound) begin
            err_val = p_val - half_val - dz_val;
        end else begin
            err_val = '0;
            cen_val = 1'b1;
        end
    end

    // Accumulate the step, saturate, then clamp to the axis limits.
    always_comb begin
        acc_cur = axis_reg ? pitch_acc_reg : yaw_acc_reg;
        sum_val = SW'(acc_cur) + SW'(step_reg);
        ovf     = (sum_val[SW-1:ACC-1] != '0) && (sum_val[SW-1:ACC-1] != '1);
        if (ovf) begin
            sat_val = sum_val[SW-1] ? $signed({1'b1, {(ACC-1){1'b0}}})
                                    : $signed({1'b0, {(ACC-1){1'b1}}});
        end else begin
            sat_val = sum_val[ACC-1:0];
        end
        lim_hi = axis_reg ? $signed(ACC'({2'b00, cfg.pitch_high_limit}) << POS_FRAC_BITS)
                          : $signed(ACC'({2'b00, cfg.yaw_high_limit}) << POS_FRAC_BITS);
        lim_lo = axis_reg ? $signed(ACC'({2'b00, cfg.pitch_low_limit}) << POS_FRAC_BITS)
                          : $signed(ACC'({2'b00, cfg.yaw_low_limit}) << POS_FRAC_BITS);
        if (sat_val > lim_hi) begin
            clamp_val = lim_hi;
        end else if (sat_val < lim_lo) begin
            clamp_val = lim_lo;
        end else begin
            clamp_val = sat_val;
        end
    end

    // Final step: commit unless both axes are centred.
    assign pitch_hi_full = $signed(ACC'({2'b00, cfg.pitch_high_limit}) << POS_FRAC_BITS);
    assign both_c    = cen_reg[0] && cen_reg[1];
    assign send      = !both_c;
    assign fin_load  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign yaw_src   = send ? new_yaw_reg : yaw_acc_reg;
    assign pitch_src = send ? new_pitch_reg : pitch_acc_reg;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_DZ;
            ST_DZ:   state_next = ST_ERR;
            ST_ERR:  state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_UPD;
            ST_UPD:  state_next = axis_reg ? ST_FIN : ST_ERR;
            ST_FIN:  if (fin_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            yaw_acc_reg   <= $signed(ACC'({2'b00, YAW_HOME}) << POS_FRAC_BITS);
            pitch_acc_reg <= $signed(ACC'({2'b00, PITCH_HOME}) << POS_FRAC_BITS);
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DZ) begin
                axis_reg <= 1'b0;
            end else if (state_reg == ST_UPD) begin
                axis_reg <= ~axis_reg;
            end
            if (fin_load) begin
                m_valid_reg   <= 1'b1;
                yaw_acc_reg   <= yaw_src;
                pitch_acc_reg <= pitch_src;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_DZ) begin
            dz_reg <= mul_full[DZW-1:0];
        end
        if (state_reg == ST_ERR) begin
            err_reg           <= err_val;
            cen_reg[axis_reg] <= cen_val;
        end
        if (state_reg == ST_MUL1) begin
            prod_reg <= mul_full[MA-1:0];
        end
        if (state_reg == ST_MUL2) begin
            step_reg <= mul_full[PW-1:SH];
        end
        if (state_reg == ST_UPD) begin
            if (axis_reg) begin
                new_pitch_reg <= clamp_val;
            end else begin
                new_yaw_reg <= clamp_val;
            end
        end
        if (fin_load) begin
            out_reg.yaw_position   <= int_part(yaw_src);
            out_reg.pitch_position <= int_part(pitch_src);
            out_reg.positions_sent <= send;
            out_reg.aim_done       <= both_c || (cen_reg[0] && (new_pitch_reg == pitch_hi_full));
            out_reg.x_centered     <= cen_reg[0];
            out_reg.y_centered     <= cen_reg[1];
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // An accepted beat always starts the sequence.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DZ))
        else $error("accepted beat did not start the sequence");

    // A result that sends nothing must report the aim as done.
    a_unsent_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.positions_sent) |-> (m_data.aim_done && m_data.x_centered
                                                 && m_data.y_centered))
        else $error("unsent result without both axes centred");

    // Both centred leaves the accumulators untouched.
    a_hold_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_load && !send) |=> (yaw_acc_reg == $past(yaw_acc_reg))
                                && (pitch_acc_reg == $past(pitch_acc_reg)))
        else $error("accumulators moved with both axes centred");

    // With ordered limits a sent yaw position lies within them.
    a_yaw_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_load && send && (cfg.yaw_low_limit <= cfg.yaw_high_limit))
        |=> (m_data.yaw_position >= $past(cfg.yaw_low_limit))
            && (m_data.yaw_position <= $past(cfg.yaw_high_limit)))
        else $error("sent yaw position outside its limits");

endmodule

`default_nettype wire

FILE: src/pth_cfg_regs.sv
// ============================================================================
// Pan-tilt head tracker configuration registers
// Write-only register file for gains, dead zone factor and servo limits.
// ============================================================================
`default_nettype none

module pth_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [pth_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pth_pkg::CFG_DATA_W-1:0] cfg_data,
    output pth_pkg::cfg_t                       cfg
);
    import pth_pkg::*;

    cfg_t cfg_reg;

    // Each write lands in one register, truncated to its width.
    // Indexes past the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.yaw_gain         <= RST_YAW_GAIN;
            cfg_reg.pitch_gain       <= RST_PITCH_GAIN;
            cfg_reg.dead_zone_factor <= RST_DZ_FACTOR;
            cfg_reg.yaw_low_limit    <= RST_YAW_LOW;
            cfg_reg.yaw_high_limit   <= RST_YAW_HIGH;
            cfg_reg.pitch_low_limit  <= RST_PITCH_LOW;
            cfg_reg.pitch_high_limit <= RST_PITCH_HIGH;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_YAW_GAIN:   cfg_reg.yaw_gain         <= cfg_data[GAIN_W-1:0];
                CFG_PITCH_GAIN: cfg_reg.pitch_gain       <= cfg_data[GAIN_W-1:0];
                CFG_DZ_FACTOR:  cfg_reg.dead_zone_factor <= cfg_data[DZF_W-1:0];
                CFG_YAW_LOW:    cfg_reg.yaw_low_limit    <= cfg_data[LIM_W-1:0];
                CFG_YAW_HIGH:   cfg_reg.yaw_high_limit   <= cfg_data[LIM_W-1:0];
                CFG_PITCH_LOW:  cfg_reg.pitch_low_limit  <= cfg_data[LIM_W-1:0];
                CFG_PITCH_HIGH: cfg_reg.pitch_high_limit <= cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire
